// ===== rtl/rdsm_pkg.sv =====
// shared types and constants for the dot-star pattern matcher
package rdsm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 5;
  localparam int CHARS_W         = 128;
  localparam int APB_AW          = 5;
  localparam int APB_DW          = 64;

  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [1:0] REG_LENGTH     = 2'd2;

  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   length;
  } rdsm_cfg_t;

endpackage

// ===== rtl/regex_dot_star_matcher.sv =====
// top level of the streaming dot-star pattern matcher
//
// channel   dir   handshake                      contents
// s_axis    in    s_axis_tvalid / s_axis_tready  tdata text_char, tuser kind
// m_axis    out   m_axis_tvalid / m_axis_tready  tdata matched
// apb       in    psel, penable, pwrite, pready  pattern bytes, pattern length
//
// one transaction in, one transaction out; one item per cycle sustained while m_axis_tready is high
// result reg and tvalid load together when the item in the input reg advances
// the column update is one combinational pass between the input and result regs
// rst_ni clears the column, so text bytes before a start give matched 0
// a stalled output holds its result while the input reg still takes one item
module regex_dot_star_matcher #(
  parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] text_char
  input  logic                        s_axis_tuser,  // [0] kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [0] matched, [7:1] zero
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdsm_pkg::APB_AW-1:0] paddr,
  input  logic [rdsm_pkg::APB_DW-1:0] pwdata,
  output logic [rdsm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rdsm_pkg::*;

  rdsm_cfg_t         cfg;
  logic              in_valid_q;
  logic              in_kind_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              out_valid_q;
  logic              out_matched_q;
  logic              advance;
  logic              accept;
  logic              matched;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign accept        = s_axis_tvalid & s_axis_tready;

  rdsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rdsm_column #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_column (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .kind_i      (in_kind_q),
    .text_char_i (in_char_q),
    .matched_o   (matched)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
    if (advance) begin
      out_matched_q <= matched;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_matched_q};

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result reg not loaded after advance");

  a_full_and_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both stages are full and stalled");

  a_out_held_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

// ===== rtl/rdsm_regs.sv =====
// apb register file holding the pattern bytes and pattern length
module rdsm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rdsm_pkg::APB_AW-1:0] paddr,
  input  logic [rdsm_pkg::APB_DW-1:0] pwdata,
  output logic [rdsm_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output rdsm_pkg::rdsm_cfg_t        cfg_o
);
  import rdsm_pkg::*;

  logic [APB_DW-1:0] chars_low_q;
  logic [APB_DW-1:0] chars_high_q;
  logic [LEN_W-1:0]  length_q;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_low_q  <= '0;
      chars_high_q <= '0;
      length_q     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHARS_LOW:  chars_low_q  <= pwdata;
        REG_CHARS_HIGH: chars_high_q <= pwdata;
        REG_LENGTH:     length_q     <= pwdata[LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHARS_LOW:  prdata = chars_low_q;
      REG_CHARS_HIGH: prdata = chars_high_q;
      REG_LENGTH:     prdata = {{(APB_DW-LEN_W){1'b0}}, length_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.chars  = {chars_high_q, chars_low_q};
  assign cfg_o.length = length_q;

endmodule

// ===== rtl/rdsm_column.sv =====
// match column register and its combinational update logic
module rdsm_column #(
  parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rdsm_pkg::rdsm_cfg_t         cfg_i,
  input  logic                        advance_i,
  input  logic                        kind_i,
  input  logic [rdsm_pkg::CHAR_W-1:0] text_char_i,
  output logic                        matched_o
);
  import rdsm_pkg::*;

  localparam int COL_W = PATTERN_MAX + 1;
  localparam int NW    = $clog2(PATTERN_MAX + 1);

  logic [COL_W-1:0]  column_q;
  logic [COL_W-1:0]  column_d;
  logic [COL_W-1:0]  col_empty;
  logic [COL_W-1:0]  col_next;
  logic [NW-1:0]     n_used;
  logic [CHAR_W-1:0] pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_v;
  logic [PATTERN_MAX-1:0] star_v;
  logic [PATTERN_MAX-1:0] active_v;

  assign n_used = (cfg_i.length > LEN_W'(PATTERN_MAX)) ? NW'(PATTERN_MAX)
                                                        : cfg_i.length[NW-1:0];

  assign col_empty[0] = 1'b1;
  assign col_next[0]  = 1'b0;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pos
    assign pat[g]      = cfg_i.chars[CHAR_W*g +: CHAR_W];
    assign hit_v[g]    = (pat[g] == DOT_CHAR) | (pat[g] == text_char_i);
    assign active_v[g] = NW'(g) < n_used;
    if (g == 0) begin : g_first
      assign star_v[g]       = 1'b0;
      assign col_empty[g+1]  = 1'b0;
      assign col_next[g+1]   = active_v[g] & column_q[g] & hit_v[g];
    end else begin : g_rest
      assign star_v[g]      = pat[g] == STAR_CHAR;
      assign col_empty[g+1] = active_v[g] & star_v[g] & col_empty[g-1];
      assign col_next[g+1]  = active_v[g] & (star_v[g]
                              ? (col_next[g-1] | (column_q[g+1] & hit_v[g-1]))
                              : (column_q[g] & hit_v[g]));
    end
  end

  assign column_d  = (kind_i == KIND_START) ? col_empty : col_next;
  assign matched_o = column_d[n_used];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
    end else if (advance_i) begin
      column_q <= column_d;
    end
  end

  a_start_sets_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && kind_i == KIND_START |=> column_q[0])
    else $error("start did not set the empty prefix bit");

  a_byte_clears_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && kind_i == KIND_BYTE |=> !column_q[0])
    else $error("text byte left the empty prefix bit set");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(column_q))
    else $error("column changed without a transaction");

endmodule
